FILE: rtl/tll_pkg.sv
`timescale 1ns / 1ps
package tll_pkg;

    localparam int DEF_MAX_TOKEN_LEN = 1023;
    localparam int DEF_KEYWORD_CHARS = 6;
    localparam int KW_MAX_LEN        = 6;
    localparam int KW_COUNT          = 8;
    localparam int Q_DEPTH           = 4;

    localparam logic [5:0] TK_LPAREN   = 6'd0;
    localparam logic [5:0] TK_RPAREN   = 6'd1;
    localparam logic [5:0] TK_LSQ      = 6'd2;
    localparam logic [5:0] TK_RSQ      = 6'd3;
    localparam logic [5:0] TK_IDENT    = 6'd4;
    localparam logic [5:0] TK_NUMBER   = 6'd5;
    localparam logic [5:0] TK_ASSIGN   = 6'd6;
    localparam logic [5:0] TK_LT       = 6'd7;
    localparam logic [5:0] TK_LQ       = 6'd8;
    localparam logic [5:0] TK_BT       = 6'd9;
    localparam logic [5:0] TK_BQ       = 6'd10;
    localparam logic [5:0] TK_EQ       = 6'd11;
    localparam logic [5:0] TK_SEMI     = 6'd12;
    localparam logic [5:0] TK_IF       = 6'd15;
    localparam logic [5:0] TK_THEN     = 6'd16;
    localparam logic [5:0] TK_ELSE     = 6'd17;
    localparam logic [5:0] TK_END      = 6'd18;
    localparam logic [5:0] TK_READ     = 6'd19;
    localparam logic [5:0] TK_WRITE    = 6'd20;
    localparam logic [5:0] TK_REPEAT   = 6'd21;
    localparam logic [5:0] TK_UNTIL    = 6'd22;
    localparam logic [5:0] TK_COMMENTS = 6'd23;
    localparam logic [5:0] TK_BITOR    = 6'd25;
    localparam logic [5:0] TK_BITAND   = 6'd26;
    localparam logic [5:0] TK_OR       = 6'd27;
    localparam logic [5:0] TK_AND      = 6'd28;
    localparam logic [5:0] TK_ADD      = 6'd29;
    localparam logic [5:0] TK_SUB      = 6'd30;
    localparam logic [5:0] TK_MUL      = 6'd31;
    localparam logic [5:0] TK_DIVI     = 6'd32;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ASSIGN  = 2'd1;
    localparam logic [1:0] ERR_COMMENT = 2'd2;
    localparam logic [1:0] ERR_LONG    = 2'd3;

    // keyword text, first character in the low byte
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'("fi"), 48'("neht"), 48'("esle"), 48'("dne"),
        48'("daer"), 48'("etirw"), 48'("taeper"), 48'("litnu")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd4, 3'd5, 3'd6, 3'd5
    };
    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        TK_IF, TK_THEN, TK_ELSE, TK_END, TK_READ, TK_WRITE, TK_REPEAT, TK_UNTIL
    };

    typedef enum logic [2:0] {
        M_START,
        M_IDENT,
        M_NUMBER,
        M_COMMENT,
        M_REL,
        M_ASSIGN,
        M_OR,
        M_AND
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [9:0]  length;
        logic [1:0]  err;
    } tok_t;

    typedef struct packed {
        tok_t t0;
        tok_t t1;
        logic two;
    } q_entry_t;

    typedef struct packed {
        mode_t mode;
        logic  pos_zero;
    } fe_status_t;

    typedef struct packed {
        mode_t      mode;
        logic       emit;
        logic [5:0] kind;
    } start_cls_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"], "_"});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    // what a character does when scanned from the start mode
    function automatic start_cls_t start_class(input logic [7:0] c);
        start_cls_t r;
        r.mode = M_START;
        r.emit = 1'b0;
        r.kind = TK_LPAREN;
        if (is_alpha(c))
        begin
            r.mode = M_IDENT;
        end
        else if (is_digit(c))
        begin
            r.mode = M_NUMBER;
        end
        else
        begin
            case (c)
                "{":     r.mode = M_COMMENT;
                "<":     begin r.mode = M_REL; r.kind = TK_LT; end
                ">":     begin r.mode = M_REL; r.kind = TK_BT; end
                ":":     r.mode = M_ASSIGN;
                "|":     r.mode = M_OR;
                "&":     r.mode = M_AND;
                "=":     begin r.emit = 1'b1; r.kind = TK_EQ;     end
                "(":     begin r.emit = 1'b1; r.kind = TK_LPAREN; end
                ")":     begin r.emit = 1'b1; r.kind = TK_RPAREN; end
                "[":     begin r.emit = 1'b1; r.kind = TK_LSQ;    end
                "]":     begin r.emit = 1'b1; r.kind = TK_RSQ;    end
                ";":     begin r.emit = 1'b1; r.kind = TK_SEMI;   end
                "+":     begin r.emit = 1'b1; r.kind = TK_ADD;    end
                "-":     begin r.emit = 1'b1; r.kind = TK_SUB;    end
                "*":     begin r.emit = 1'b1; r.kind = TK_MUL;    end
                "/":     begin r.emit = 1'b1; r.kind = TK_DIVI;   end
                default: r.mode = M_START;
            endcase
        end
        return r;
    endfunction

    // compare all keywords at once; only the first len bytes of txt are looked at
    function automatic logic [5:0] kw_lookup(input logic [47:0] txt, input logic [2:0] len);
        logic [5:0]  kind;
        logic [47:0] msk;
        kind = TK_IDENT;
        msk  = ~({48{1'b1}} << {len, 3'b000});
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (KW_LEN[k] == len && (txt & msk) == KW_TEXT[k])
            begin
                kind = KW_KIND[k];
            end
        end
        return kind;
    endfunction

endpackage

FILE: rtl/tll_if.sv
`timescale 1ns / 1ps
interface tll_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface tll_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [9:0]  token_length;
    logic [1:0]  error_code;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start, output token_length,
                    output error_code, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start, input token_length,
                    input error_code, input last_of_run, output ready);
endinterface

FILE: rtl/tll_front.sv
`timescale 1ns / 1ps
module tll_front
    import tll_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
    parameter int KEYWORD_CHARS = DEF_KEYWORD_CHARS
)
(
    input  logic       clk,
    input  logic       rst_n,
    tll_in_if.sink     char_ch,
    output logic       q_push,
    output q_entry_t   q_data,
    input  logic       q_full,
    output fe_status_t stat
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [LEN_W-1:0] KW_DEPTH = LEN_W'(KEYWORD_CHARS);
    localparam logic [LEN_W-1:0] KW_SPAN  = LEN_W'(KW_MAX_LEN);

    mode_t            mode_reg, mode_next;
    logic [31:0]      start_reg, start_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             tl_reg, tl_next;
    logic [5:0]       pend_reg, pend_next;
    logic [31:0]      pos_reg, pos_next;
    logic [7:0]       kw_reg [KEYWORD_CHARS];

    logic             accept;
    logic [7:0]       c;
    logic             eoi;
    logic             alpha, digit, cont, hit, rescan, begins, grows;
    logic             at_max, tl_app, prim_v, single_v;
    logic [LEN_W-1:0] len_app;
    logic [LEN_W+9:0] len_ext, app_ext;
    logic             kw_wr;
    logic [LEN_W-1:0] kw_idx;
    logic [47:0]      kw_txt;
    logic [5:0]       ident_kind;
    start_cls_t       cls;
    tok_t             prim_tok, single_tok;

    assign char_ch.ready = !q_full;
    assign accept        = char_ch.valid && char_ch.ready;
    assign c             = char_ch.char_in;
    assign eoi           = char_ch.end_of_input;
    assign alpha         = is_alpha(c);
    assign digit         = is_digit(c);
    assign cls           = start_class(c);

    always_comb
    begin
        case (mode_reg)
            M_IDENT:          cont = alpha || digit;
            M_NUMBER:         cont = digit;
            M_COMMENT:        cont = 1'b1;
            M_REL, M_ASSIGN:  cont = (c == "=");
            M_OR:             cont = (c == "|");
            M_AND:            cont = (c == "&");
            default:          cont = 1'b0;
        endcase
    end

    assign hit     = cont && !eoi;
    assign rescan  = !eoi && !cont;
    assign begins  = rescan && (cls.mode != M_START);
    assign grows   = hit && (mode_reg inside {M_IDENT, M_NUMBER, M_COMMENT});
    assign at_max  = (len_reg >= LEN_MAX);
    assign len_app = at_max ? len_reg : len_reg + 1'b1;
    assign tl_app  = tl_reg || at_max;
    assign len_ext = {10'd0, len_reg};
    assign app_ext = {10'd0, len_app};

    // keyword text is only ever compared up to the current length
    assign kw_txt = {kw_reg[5], kw_reg[4], kw_reg[3], kw_reg[2], kw_reg[1], kw_reg[0]};
    always_comb
    begin
        if (tl_reg || len_reg > KW_SPAN || len_reg > KW_DEPTH)
        begin
            ident_kind = TK_IDENT;
        end
        else
        begin
            ident_kind = kw_lookup(kw_txt, len_reg[2:0]);
        end
    end

    // next scan mode
    always_comb
    begin
        if (eoi)
        begin
            mode_next = M_START;
        end
        else if (rescan)
        begin
            mode_next = cls.mode;
        end
        else
        begin
            case (mode_reg)
                M_IDENT, M_NUMBER: mode_next = mode_reg;
                M_COMMENT:         mode_next = (c == "}") ? M_START : M_COMMENT;
                default:           mode_next = M_START;
            endcase
        end
    end

    // token bookkeeping and emitted tokens
    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        tl_next    = tl_reg;
        pend_next  = pend_reg;
        pos_next   = eoi ? 32'd0 : pos_reg + 32'd1;
        kw_wr      = 1'b0;
        kw_idx     = len_reg;
        if (begins)
        begin
            start_next = pos_reg;
            len_next   = LEN_W'(1);
            tl_next    = 1'b0;
            pend_next  = cls.kind;
            kw_wr      = 1'b1;
            kw_idx     = '0;
        end
        else if (grows)
        begin
            len_next = len_app;
            tl_next  = tl_app;
            kw_wr    = (len_reg < KW_DEPTH);
        end

        prim_tok.start  = start_reg;
        prim_tok.kind   = TK_IDENT;
        prim_tok.length = 10'd1;
        prim_tok.err    = ERR_NONE;
        case (mode_reg)
            M_IDENT:
            begin
                prim_tok.kind   = ident_kind;
                prim_tok.length = len_ext[9:0];
                prim_tok.err    = tl_reg ? ERR_LONG : ERR_NONE;
            end
            M_NUMBER:
            begin
                prim_tok.kind   = TK_NUMBER;
                prim_tok.length = len_ext[9:0];
                prim_tok.err    = tl_reg ? ERR_LONG : ERR_NONE;
            end
            M_COMMENT:
            begin
                prim_tok.kind = TK_COMMENTS;
                if (eoi)
                begin
                    prim_tok.length = len_ext[9:0];
                    prim_tok.err    = ERR_COMMENT;
                end
                else
                begin
                    prim_tok.length = app_ext[9:0];
                    prim_tok.err    = tl_app ? ERR_LONG : ERR_NONE;
                end
            end
            M_REL:
            begin
                if (hit)
                begin
                    prim_tok.kind   = (pend_reg == TK_LT) ? TK_LQ : TK_BQ;
                    prim_tok.length = 10'd2;
                end
                else
                begin
                    prim_tok.kind = pend_reg;
                end
            end
            M_ASSIGN:
            begin
                prim_tok.kind   = TK_ASSIGN;
                prim_tok.length = hit ? 10'd2 : 10'd1;
                prim_tok.err    = hit ? ERR_NONE : ERR_ASSIGN;
            end
            M_OR:
            begin
                prim_tok.kind   = hit ? TK_OR : TK_BITOR;
                prim_tok.length = hit ? 10'd2 : 10'd1;
            end
            M_AND:
            begin
                prim_tok.kind   = hit ? TK_AND : TK_BITAND;
                prim_tok.length = hit ? 10'd2 : 10'd1;
            end
            default:
            begin
                prim_tok.kind = TK_IDENT;
            end
        endcase

        single_tok.kind   = cls.kind;
        single_tok.start  = pos_reg;
        single_tok.length = 10'd1;
        single_tok.err    = ERR_NONE;
    end

    assign prim_v   = (mode_reg != M_START) &&
                      (eoi || !cont || (mode_reg inside {M_REL, M_ASSIGN, M_OR, M_AND}) ||
                       (mode_reg == M_COMMENT && c == "}"));
    assign single_v = rescan && cls.emit;

    // pack the tokens of one character so that the first slot is always filled
    assign q_data.t0  = prim_v ? prim_tok : single_tok;
    assign q_data.t1  = single_tok;
    assign q_data.two = prim_v && single_v;
    assign q_push     = accept && (prim_v || single_v);

    assign stat.mode     = mode_reg;
    assign stat.pos_zero = (pos_reg == 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_START;
            start_reg <= '0;
            len_reg   <= '0;
            tl_reg    <= 1'b0;
            pend_reg  <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            tl_reg    <= tl_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KEYWORD_CHARS; i++)
        begin
            if (accept && kw_wr && kw_idx == LEN_W'(i))
            begin
                kw_reg[i] <= c;
            end
        end
    end

endmodule

FILE: rtl/tll_queue.sv
`timescale 1ns / 1ps
module tll_queue
    import tll_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output q_entry_t pop_data,
    output logic     empty
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

    q_entry_t         slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_FULL);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/tll_back.sv
`timescale 1ns / 1ps
module tll_back
    import tll_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  q_entry_t q_data,
    output logic     q_pop,
    tll_out_if.source token_ch
);

    logic out_v_reg, out_v_next;
    tok_t out_tok_reg, out_tok_next;
    logic out_last_reg, out_last_next;
    logic hold_v_reg, hold_v_next;
    tok_t hold_tok_reg, hold_tok_next;
    logic slot_free;

    assign slot_free = !out_v_reg || token_ch.ready;
    assign q_pop     = slot_free && !hold_v_reg && !q_empty;

    always_comb
    begin
        out_v_next    = out_v_reg;
        out_tok_next  = out_tok_reg;
        out_last_next = out_last_reg;
        hold_v_next   = hold_v_reg;
        hold_tok_next = hold_tok_reg;
        if (slot_free)
        begin
            if (hold_v_reg)
            begin
                out_v_next    = 1'b1;
                out_tok_next  = hold_tok_reg;
                out_last_next = 1'b1;
                hold_v_next   = 1'b0;
            end
            else if (!q_empty)
            begin
                // park the second token of a pair until the first is taken
                out_v_next    = 1'b1;
                out_tok_next  = q_data.t0;
                out_last_next = !q_data.two;
                hold_v_next   = q_data.two;
                hold_tok_next = q_data.t1;
            end
            else
            begin
                out_v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            hold_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            hold_v_reg <= hold_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
        hold_tok_reg <= hold_tok_next;
    end

    assign token_ch.valid        = out_v_reg;
    assign token_ch.token_kind   = out_tok_reg.kind;
    assign token_ch.token_start  = out_tok_reg.start;
    assign token_ch.token_length = out_tok_reg.length;
    assign token_ch.error_code   = out_tok_reg.err;
    assign token_ch.last_of_run  = out_last_reg;

endmodule

FILE: rtl/tiny_language_lexer.sv
`timescale 1ns / 1ps
// Path: the tokens caused by a character are registered in the token queue, then in the
// output register; the second token of a pair waits in a hold register until the first is taken.
// Throughput: one character per cycle while the 4-entry token queue has room; the output
// register delivers at most one token per cycle, which bounds the rate on operator-dense text.
// Reset: rst_n clears the scan mode, position and length counters, queue and output valid.
module tiny_language_lexer
    import tll_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
    parameter int KEYWORD_CHARS = DEF_KEYWORD_CHARS
)
(
    input  logic      clk,
    input  logic      rst_n,
    tll_in_if.sink    char_ch,
    tll_out_if.source token_ch
);

    logic       q_push, q_full, q_pop, q_empty;
    q_entry_t   q_wdata, q_rdata;
    fe_status_t fe_stat;

    tll_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_ch (char_ch),
        .q_push  (q_push),
        .q_data  (q_wdata),
        .q_full  (q_full),
        .stat    (fe_stat)
    );

    tll_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    tll_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .token_ch (token_ch)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("token request pushed into a full queue");

    a_eoi_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (char_ch.valid && char_ch.ready && char_ch.end_of_input)
        |=> (fe_stat.mode == M_START && fe_stat.pos_zero))
        else $error("end of input did not return the scanner to start");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        token_ch.valid |-> token_ch.token_kind <= TK_DIVI)
        else $error("token kind out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("token request taken from an empty queue");
`endif

endmodule
